// ===== sv/srps_pkg.sv =====
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types, constants and helpers for the summed-RSSI parent selector.
// ----------------------------------------------------------------------------
package srps_pkg;

	// Beacon item
	typedef struct packed {
		logic [15:0]        neighbor_addr;
		logic signed [15:0] advertised_metric;
		logic signed [7:0]  link_rssi;
	} item_t;

	// Result item
	typedef struct packed {
		logic               table_full_drop;
		logic               parent_valid;
		logic [15:0]        parent_addr;
		logic signed [15:0] own_metric;
	} result_t;

	// Metric meaning "no route"
	localparam logic signed [15:0] NO_ROUTE = -16'sd1000;

	// Table word: address in the upper half, path sum in the lower half
	localparam int unsigned ENTRY_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_LOOK_END,
		ST_UPDATE,
		ST_SCAN,
		ST_SCAN_END,
		ST_FINISH
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;   // capture beacon
		logic look;   // issue lookup read, step pointer up
		logic upd;    // write entry, arm scan
		logic scan;   // issue scan read, step pointer down
		logic fin;    // commit selection, present result
		logic drop;   // result flags a full-table drop
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic look_done;
		logic scan_done;
		logic hit;
		logic full;
		logic is_root;
	} status_t;

	// Advertised metric plus link RSSI, saturated to 16 bits signed
	function automatic logic signed [15:0] sat_sum(logic signed [15:0] adv,
			logic signed [7:0] rssi);
		logic signed [16:0] s;
		s = {adv[15], adv} + {{9{rssi[7]}}, rssi};
		if (s[16] != s[15]) begin
			return s[16] ? 16'sh8000 : 16'sh7fff;
		end
		return s[15:0];
	endfunction

endpackage

// ===== sv/srps_ram.sv =====
// ----------------------------------------------------------------------------
// srps_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/srps_ctrl.sv =====
// ----------------------------------------------------------------------------
// srps_ctrl
// Sequencer: lookup pass, entry update, best-parent scan, result.
// ----------------------------------------------------------------------------
module srps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  srps_pkg::status_t st,
	output srps_pkg::cmd_t    cmd,
	output logic              busy
);

	import srps_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (st.look_done) begin
					state_d = ST_LOOK_END;
				end else begin
					cmd.look = 1'b1;
				end
			end
			ST_LOOK_END: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (!st.hit && st.full) begin
					cmd.fin  = 1'b1;
					cmd.drop = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cmd.upd = 1'b1;
					state_d = st.is_root ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					state_d = ST_SCAN_END;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_SCAN_END: state_d = ST_FINISH;
			ST_FINISH: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== sv/srps_dp.sv =====
// ----------------------------------------------------------------------------
// srps_dp
// Datapath: neighbor table RAM, fill count, pointers, compare units, node state.
// ----------------------------------------------------------------------------
module srps_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srps_pkg::item_t   item,
	input  srps_pkg::cmd_t    cmd,
	input  logic              cfg_we,
	input  logic              cfg_root,
	output srps_pkg::status_t st,
	output logic              done,
	output srps_pkg::result_t result
);

	import srps_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	item_t              item_q;
	logic signed [15:0] sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               hit_q;
	logic [IDX_W-1:0]   slot_q;
	logic signed [15:0] best_q;
	logic               win_q;
	logic [15:0]        win_addr_q;
	logic               is_root_q;
	logic [15:0]        parent_q;
	logic               have_q;
	logic signed [15:0] metric_q;
	logic               done_q;
	result_t            result_q;

	logic               rd_look_s1;
	logic               rd_scan_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic [CNT_W-1:0]   ptr_dec;
	logic [CNT_W-1:0]   cnt_inc;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [15:0]        rd_addr;
	logic signed [15:0] rd_sum;
	logic               look_match;
	logic               scan_better;

	logic [15:0]        parent_n;
	logic               have_n;
	logic signed [15:0] metric_n;

	assign ptr_dec = ptr_q - 1'b1;
	assign cnt_inc = cnt_q + 1'b1;
	assign raddr   = cmd.scan ? ptr_dec[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign waddr   = hit_q ? slot_q : cnt_q[IDX_W-1:0];
	assign wdata   = {item_q.neighbor_addr, sum_q};
	assign rd_addr = rdata[31:16];
	assign rd_sum  = signed'(rdata[15:0]);

	assign look_match  = rd_look_s1 && !hit_q && (rd_addr == item_q.neighbor_addr);
	assign scan_better = rd_scan_s1 && (rd_sum > best_q) && (rd_sum < 16'sd0);

	srps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// read tags travel with the registered RAM output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_look_s1 <= 1'b0;
			rd_scan_s1 <= 1'b0;
		end else begin
			rd_look_s1 <= cmd.look;
			rd_scan_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
	end

	// beacon capture, lookup and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			hit_q <= 1'b0;
			win_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
				win_q <= 1'b0;
			end
			if (cmd.look) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (look_match) begin
				hit_q <= 1'b1;
			end
			if (cmd.upd) begin
				if (hit_q) begin
					ptr_q <= cnt_q;
				end else begin
					cnt_q <= cnt_inc;
					ptr_q <= cnt_inc;
				end
			end
			if (cmd.scan) begin
				ptr_q <= ptr_dec;
			end
			if (scan_better) begin
				win_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			sum_q  <= sat_sum(item.advertised_metric, item.link_rssi);
		end
		if (look_match) begin
			slot_q <= rd_idx_s1;
		end
		if (cmd.upd) begin
			best_q <= NO_ROUTE;
		end
		if (scan_better) begin
			best_q     <= rd_sum;
			win_addr_q <= rd_addr;
		end
	end

	// node state and result
	always_comb begin
		parent_n = parent_q;
		have_n   = have_q;
		metric_n = metric_q;
		if (win_q) begin
			parent_n = win_addr_q;
			have_n   = 1'b1;
			metric_n = best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_root_q <= 1'b0;
			parent_q  <= '0;
			have_q    <= 1'b0;
			metric_q  <= NO_ROUTE;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cfg_we) begin
				is_root_q <= cfg_root;
				metric_q  <= cfg_root ? 16'sd0 : NO_ROUTE;
			end
			if (cmd.fin) begin
				parent_q <= parent_n;
				have_q   <= have_n;
				metric_q <= metric_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result_q.table_full_drop <= cmd.drop;
			result_q.parent_valid    <= have_n;
			result_q.parent_addr     <= parent_n;
			result_q.own_metric      <= is_root_q ? 16'sd0 : metric_n;
		end
	end

	assign st.look_done = (ptr_q == cnt_q);
	assign st.scan_done = (ptr_q == '0);
	assign st.hit       = hit_q;
	assign st.full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign st.is_root   = is_root_q;

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/summed_rssi_parent_selector.sv =====
// ----------------------------------------------------------------------------
// summed_rssi_parent_selector
// Neighbor table with summed-RSSI best-parent selection, one result per beacon.
// ----------------------------------------------------------------------------
// A beacon is taken when start is high and busy is low; busy then stays high
// until the beacon is fully processed, and in the first cycle with busy low
// the result shows on result for exactly one cycle, marked by done. There is
// no back-pressure on the result side: capture it when done is high. A
// full-table drop skips the entry update and the parent scan, and a root
// node skips the parent scan. The single read port of the table RAM sets
// the pace: the address lookup and the newest-first parent scan each read
// one entry per cycle. is_root is written over the cfg transfer channel,
// which is ready whenever the block is not busy; a write reloads the node
// metric (0 at the root, -1000 otherwise). Entries are never freed, so the
// table fills in slot order and a fill count stands in for per-entry valid
// bits.
// ----------------------------------------------------------------------------
module summed_rssi_parent_selector #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// beacon command
	input  logic              start,
	output logic              busy,
	input  srps_pkg::item_t   item,
	// result strobe
	output logic              done,
	output srps_pkg::result_t result,
	// is_root register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	import srps_pkg::*;

	cmd_t    cmd;
	status_t st;

	// config transfers only land between beacons
	assign cfg_ready = !busy;

	srps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	srps_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_root (cfg_data),
		.st       (st),
		.done     (done),
		.result   (result)
	);

	// a taken beacon always makes the block busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beacon did not raise busy");

	// a result only follows a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// the result appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

endmodule
